@@ sv/mllc_pkg.sv @@
`default_nettype none
package mllc_pkg;

   localparam int REG_W       = 10;
   localparam int LIGHT_W     = 10;
   localparam int BRIGHT_W    = 10;
   localparam int LED_W       = 3;
   localparam int CHIME_W     = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_FIELD_W = 17;

   // rsp tdata field positions
   localparam int RSP_UPD_BIT   = 10;
   localparam int RSP_LED_LSB   = 11;
   localparam int RSP_SHADE_BIT = 14;
   localparam int RSP_CHIME_LSB = 15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFF_LIMIT          = 3'd0,
      CSR_FIRST_BAND_TOP     = 3'd1,
      CSR_SECOND_BAND_BOTTOM = 3'd2,
      CSR_THIRD_BAND_BOTTOM  = 3'd3,
      CSR_THIRD_BAND_TOP     = 3'd4,
      CSR_SHADE_LIMIT        = 3'd5
   } csr_index_type;

   localparam logic [REG_W-1:0] OFF_LIMIT_RST          = 10'd350;
   localparam logic [REG_W-1:0] FIRST_BAND_TOP_RST     = 10'd500;
   localparam logic [REG_W-1:0] SECOND_BAND_BOTTOM_RST = 10'd550;
   localparam logic [REG_W-1:0] THIRD_BAND_BOTTOM_RST  = 10'd800;
   localparam logic [REG_W-1:0] THIRD_BAND_TOP_RST     = 10'd1023;
   localparam logic [REG_W-1:0] SHADE_LIMIT_RST        = 10'd100;

   typedef enum logic [1:0] {
      SHADE_UNKNOWN = 2'd0,
      SHADE_CLOSED  = 2'd1,
      SHADE_OPEN    = 2'd2
   } shade_type;

   localparam logic [CHIME_W-1:0] CHIME_NONE    = 2'd0;
   localparam logic [CHIME_W-1:0] CHIME_CLOSING = 2'd1;
   localparam logic [CHIME_W-1:0] CHIME_OPENING = 2'd2;

   localparam logic [LED_W-1:0] LED_OFF    = 3'd0;
   localparam logic [LED_W-1:0] LED_FIRST  = 3'd2;
   localparam logic [LED_W-1:0] LED_SECOND = 3'd5;
   localparam logic [LED_W-1:0] LED_THIRD  = 3'd7;

   typedef struct packed {
      logic insert;
      logic evaluate;
   } dp_cmd_type;

endpackage
`default_nettype wire

@@ sv/mllc_datapath.sv @@
`default_nettype none
module mllc_datapath
   import mllc_pkg::*;
#(
   parameter int WINDOW      = 10,
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dp_cmd_type           cmd,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata,
   input  wire logic [LIGHT_W-1:0]   light_sample,
   input  wire logic                 motion_level,
   output logic [BRIGHT_W-1:0]       brightness,
   output logic                      median_updated,
   output logic [LED_W-1:0]          led_pattern,
   output logic                      shade_closed,
   output logic [CHIME_W-1:0]        chime
);

   localparam int SW  = (SAMPLE_BITS < LIGHT_W) ? SAMPLE_BITS : LIGHT_W;
   localparam int CW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int MID = WINDOW / 2;

   logic [REG_W-1:0] off_limit_ff, first_top_ff, second_bot_ff;
   logic [REG_W-1:0] third_bot_ff, third_top_ff, shade_limit_ff;

   // window kept sorted in descending order, one insertion per beat
   logic [SW-1:0] row_ff [WINDOW];
   logic [SW-1:0] row_in [WINDOW];
   logic          ge     [WINDOW];
   logic [SW-1:0] sample;
   logic [CW-1:0] fill_ff, fill_in;
   logic          full_ff, full_in;
   logic          motion_ff;

   logic [BRIGHT_W-1:0] held_ff, held_in;
   logic [LED_W-1:0]    led_ff, led_in;
   shade_type           shade_ff, shade_in;
   logic                closed;
   logic [CHIME_W-1:0]  chime_in;
   logic [BRIGHT_W-1:0] median;

   logic [BRIGHT_W-1:0] out_bright_ff;
   logic                out_upd_ff, out_closed_ff;
   logic [LED_W-1:0]    out_led_ff;
   logic [CHIME_W-1:0]  out_chime_ff;

   assign sample = light_sample[SW-1:0];

   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         ge[i] = (fill_ff > CW'(i)) && (row_ff[i] >= sample);
      end
      row_in[0] = ge[0] ? row_ff[0] : sample;
      for (int i = 1; i < WINDOW; i++) begin
         if (ge[i]) begin
            row_in[i] = row_ff[i];
         end else if (ge[i-1]) begin
            row_in[i] = sample;
         end else begin
            row_in[i] = row_ff[i-1];
         end
      end
      full_in = (fill_ff == CW'(WINDOW - 1));
      fill_in = full_in ? '0 : fill_ff + 1'b1;
   end

   always_comb begin
      median  = BRIGHT_W'(row_ff[MID]);
      held_in = full_ff ? median : held_ff;
      if (motion_ff) begin
         if (held_in < off_limit_ff) begin
            led_in = LED_OFF;
         end else if (held_in < first_top_ff) begin
            led_in = LED_FIRST;
         end else if (held_in >= second_bot_ff && held_in < third_bot_ff) begin
            led_in = LED_SECOND;
         end else if (held_in >= third_bot_ff && held_in < third_top_ff) begin
            led_in = LED_THIRD;
         end else begin
            led_in = led_ff;
         end
      end else begin
         led_in = (held_in >= off_limit_ff) ? LED_FIRST : LED_OFF;
      end
      closed = (held_in < shade_limit_ff);
      if (closed) begin
         shade_in = SHADE_CLOSED;
         chime_in = (shade_ff != SHADE_CLOSED) ? CHIME_CLOSING : CHIME_NONE;
      end else begin
         shade_in = SHADE_OPEN;
         chime_in = (shade_ff != SHADE_OPEN) ? CHIME_OPENING : CHIME_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_limit_ff   <= OFF_LIMIT_RST;
         first_top_ff   <= FIRST_BAND_TOP_RST;
         second_bot_ff  <= SECOND_BAND_BOTTOM_RST;
         third_bot_ff   <= THIRD_BAND_BOTTOM_RST;
         third_top_ff   <= THIRD_BAND_TOP_RST;
         shade_limit_ff <= SHADE_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OFF_LIMIT:          off_limit_ff   <= csr_wdata;
            CSR_FIRST_BAND_TOP:     first_top_ff   <= csr_wdata;
            CSR_SECOND_BAND_BOTTOM: second_bot_ff  <= csr_wdata;
            CSR_THIRD_BAND_BOTTOM:  third_bot_ff   <= csr_wdata;
            CSR_THIRD_BAND_TOP:     third_top_ff   <= csr_wdata;
            CSR_SHADE_LIMIT:        shade_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         held_ff  <= '0;
         led_ff   <= LED_OFF;
         shade_ff <= SHADE_UNKNOWN;
      end else begin
         if (cmd.insert) begin
            fill_ff <= fill_in;
         end
         if (cmd.evaluate) begin
            held_ff  <= held_in;
            led_ff   <= led_in;
            shade_ff <= shade_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         row_ff    <= row_in;
         full_ff   <= full_in;
         motion_ff <= motion_level;
      end
      if (cmd.evaluate) begin
         out_bright_ff <= held_in;
         out_upd_ff    <= full_ff;
         out_led_ff    <= led_in;
         out_closed_ff <= closed;
         out_chime_ff  <= chime_in;
      end
   end

   assign brightness     = out_bright_ff;
   assign median_updated = out_upd_ff;
   assign led_pattern    = out_led_ff;
   assign shade_closed   = out_closed_ff;
   assign chime          = out_chime_ff;

endmodule
`default_nettype wire

@@ sv/mllc_ctrl.sv @@
`default_nettype none
module mllc_ctrl
   import mllc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output dp_cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EVAL
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == S_IDLE);
   assign cmd.insert   = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.evaluate = (state_ff == S_EVAL) && out_free;
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) state_ff <= S_EVAL;
            end
            S_EVAL: begin
               // hold here while the previous result is still unclaimed
               if (out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (cmd.evaluate) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

@@ sv/median_light_level_classifier.sv @@
// order: the input beat is inserted into the sorted window row, then the evaluate
// state registers the result beat, held back while an earlier result waits on rsp_tready
// flow: one item at a time; req_tready stays low from the insertion into the
// sorted window row until the evaluate step for that item has run
// reset: synchronous, active high; clears window fill, held brightness, held leds,
// shade state and loads the register defaults
`default_nettype none
module median_light_level_classifier
   import mllc_pkg::*;
#(
   parameter int WINDOW      = 10,
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // light_sample[9:0], motion_level[10]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // brightness[9:0], median_updated[10],
                                                   // led_pattern[13:11], shade_closed[14],
                                                   // chime[16:15]
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [REG_W-1:0]      csr_wdata
);

   dp_cmd_type          cmd;
   logic [BRIGHT_W-1:0] brightness;
   logic                median_updated;
   logic [LED_W-1:0]    led_pattern;
   logic                shade_closed;
   logic [CHIME_W-1:0]  chime;

   mllc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mllc_datapath #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .light_sample   (req_tdata[LIGHT_W-1:0]),
      .motion_level   (req_tdata[LIGHT_W]),
      .brightness     (brightness),
      .median_updated (median_updated),
      .led_pattern    (led_pattern),
      .shade_closed   (shade_closed),
      .chime          (chime)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RSP_FIELD_W){1'b0}},
                       chime, shade_closed, led_pattern, median_updated, brightness};

endmodule
`default_nettype wire

@@ sv/mllc_checker.sv @@
`default_nettype none
module mllc_checker
   import mllc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [LED_W-1:0]   led;
   logic [CHIME_W-1:0] chm;
   logic               shd;

   assign led = rsp_tdata[RSP_LED_LSB +: LED_W];
   assign chm = rsp_tdata[RSP_CHIME_LSB +: CHIME_W];
   assign shd = rsp_tdata[RSP_SHADE_BIT];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped before it was taken");

   a_chime_shade: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (chm == CHIME_NONE) || (chm == CHIME_CLOSING && shd)
                     || (chm == CHIME_OPENING && !shd))
      else $error("chime does not match shade direction");

   a_led_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (led == LED_OFF) || (led == LED_FIRST)
                     || (led == LED_SECOND) || (led == LED_THIRD))
      else $error("led pattern outside the four bands");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("result beat late with output free");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in flight");

endmodule

bind median_light_level_classifier mllc_checker u_mllc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

@@ verif/median_light_level_classifier_tb.sv @@
module median_light_level_classifier_tb;
   import mllc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_LEN  = 10;
   localparam int NUM_REGS    = 6;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_WINS  = 12;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 3000;
   localparam int LIGHT_MAX   = (1 << LIGHT_W) - 1;

   typedef struct packed {
      logic               motion;
      logic [LIGHT_W-1:0] light;
   } light_item_type;

   typedef struct packed {
      logic [BRIGHT_W-1:0] brightness;
      logic                updated;
      logic [LED_W-1:0]    led;
      logic                shade_closed;
      logic [CHIME_W-1:0]  chime;
   } light_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // light_sample[9:0], motion_level[10]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // brightness[9:0], median_updated[10],
                                             // led_pattern[13:11], shade_closed[14],
                                             // chime[16:15]
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [REG_W-1:0]      csr_wdata  = '0;

   median_light_level_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // classifier state mirrored in the bench
   logic [REG_W-1:0]   band_reg [NUM_REGS] = '{OFF_LIMIT_RST, FIRST_BAND_TOP_RST,
                                               SECOND_BAND_BOTTOM_RST, THIRD_BAND_BOTTOM_RST,
                                               THIRD_BAND_TOP_RST, SHADE_LIMIT_RST};
   logic [LIGHT_W-1:0] win_store [WINDOW_LEN];
   int                 fill_cnt     = 0;
   logic [BRIGHT_W-1:0] held_level  = '0;
   logic [LED_W-1:0]   led_now      = LED_OFF;
   shade_type          shade_now    = SHADE_UNKNOWN;

   light_item_type     sample_q [$];
   light_result_type   classified_q [$];
   light_item_type     offered;
   logic               req_taken    = 1'b0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   logic               rsp_hold     = 1'b0;
   logic               pressure_go  = 1'b0;
   int                 fail_count   = 0;
   int                 quiet_cycles = 0;

   function automatic light_result_type classify_sample(logic [LIGHT_W-1:0] sample,
                                                        logic motion);
      logic [LIGHT_W-1:0] sorted [WINDOW_LEN];
      logic [LIGHT_W-1:0] v;
      light_result_type   r;
      int                 i, j;
      r = '0;
      if (fill_cnt >= WINDOW_LEN) fill_cnt = 0;
      win_store[fill_cnt] = sample;
      fill_cnt++;
      if (fill_cnt >= WINDOW_LEN) begin
         sorted = win_store;
         // descending insertion sort, median is the middle slot
         for (i = 1; i < WINDOW_LEN; i++) begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] < v) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = v;
         end
         held_level = sorted[WINDOW_LEN/2];
         fill_cnt = 0;
         r.updated = 1'b1;
      end
      if (motion) begin
         if (held_level < band_reg[CSR_OFF_LIMIT]) begin
            led_now = LED_OFF;
         end else if (held_level < band_reg[CSR_FIRST_BAND_TOP]) begin
            led_now = LED_FIRST;
         end else if (held_level >= band_reg[CSR_SECOND_BAND_BOTTOM] &&
                      held_level < band_reg[CSR_THIRD_BAND_BOTTOM]) begin
            led_now = LED_SECOND;
         end else if (held_level >= band_reg[CSR_THIRD_BAND_BOTTOM] &&
                      held_level < band_reg[CSR_THIRD_BAND_TOP]) begin
            led_now = LED_THIRD;
         end
      end else begin
         led_now = (held_level >= band_reg[CSR_OFF_LIMIT]) ? LED_FIRST : LED_OFF;
      end
      r.shade_closed = held_level < band_reg[CSR_SHADE_LIMIT];
      if (r.shade_closed) begin
         r.chime = (shade_now != SHADE_CLOSED) ? CHIME_CLOSING : CHIME_NONE;
         shade_now = SHADE_CLOSED;
      end else begin
         r.chime = (shade_now != SHADE_OPEN) ? CHIME_OPENING : CHIME_NONE;
         shade_now = SHADE_OPEN;
      end
      r.brightness = held_level;
      r.led = led_now;
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         classified_q.push_back(classify_sample(offered.light, offered.motion));
         req_taken <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offered = sample_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_DATA_W'({offered.motion, offered.light});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_taken <= 1'b0;
   end

   // response monitor
   always @(negedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : rsp_check
      light_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (classified_q.size() == 0) begin
            $display("%0t: result beat with none pending, expected none, actual %h",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            want = classified_q.pop_front();
            check_field("brightness", want.brightness, rsp_tdata[BRIGHT_W-1:0]);
            check_field("median_updated", want.updated, rsp_tdata[RSP_UPD_BIT]);
            check_field("led_pattern", want.led, rsp_tdata[RSP_LED_LSB +: LED_W]);
            check_field("shade_closed", want.shade_closed, rsp_tdata[RSP_SHADE_BIT]);
            check_field("chime", want.chime, rsp_tdata[RSP_CHIME_LSB +: CHIME_W]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // long receiver stall so the block backs up into the request side
   initial begin
      wait (pressure_go);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   task automatic program_bands(input logic [REG_W-1:0] vals [NUM_REGS]);
      csr_index_type idx;
      for (int k = 0; k < NUM_REGS; k++) begin
         idx = csr_index_type'(k);
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[k];
         band_reg[idx] = vals[k];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_windows(input int count);
      light_item_type it;
      int             level, pick, motion_mode;
      logic           noisy;
      for (int w = 0; w < count; w++) begin
         pick  = $urandom_range(9);
         noisy = (pick >= 8);
         if (pick <= 4) begin
            // park the median on or next to a threshold
            level = int'(band_reg[$urandom_range(NUM_REGS-1)]) + int'($urandom_range(2)) - 1;
            if (level < 0) level = 0;
            if (level > LIGHT_MAX) level = LIGHT_MAX;
         end else if (pick == 7) begin
            level = $urandom_range(1) ? LIGHT_MAX : 0;
         end else begin
            level = $urandom_range(LIGHT_MAX);
         end
         motion_mode = $urandom_range(2);
         for (int k = 0; k < WINDOW_LEN; k++) begin
            it.light  = (!noisy && $urandom_range(99) < 70) ? LIGHT_W'(level)
                                                            : LIGHT_W'($urandom_range(LIGHT_MAX));
            it.motion = (motion_mode == 2) ? 1'($urandom_range(1)) : 1'(motion_mode);
            sample_q.push_back(it);
         end
      end
   endtask

   task automatic settle();
      while (sample_q.size() != 0 || req_tvalid || classified_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic [REG_W-1:0]   vals [NUM_REGS];
      logic [LIGHT_W-1:0] first_win [WINDOW_LEN];
      light_item_type     it;
      first_win = '{0, 1023, 1, 1022, 512, 511, 341, 682, 341, 682};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 72 : 0;
         recv_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 28 : 0;
         case (ph)
            1, 5: begin
               vals[CSR_OFF_LIMIT]          = REG_W'($urandom_range(400));
               vals[CSR_FIRST_BAND_TOP]     = REG_W'(vals[CSR_OFF_LIMIT]
                                                     + $urandom_range(200));
               vals[CSR_SECOND_BAND_BOTTOM] = REG_W'(vals[CSR_FIRST_BAND_TOP]
                                                     + $urandom_range(100));
               vals[CSR_THIRD_BAND_BOTTOM]  = REG_W'(vals[CSR_SECOND_BAND_BOTTOM]
                                                     + $urandom_range(200));
               vals[CSR_THIRD_BAND_TOP]     = REG_W'(vals[CSR_THIRD_BAND_BOTTOM]
                                                     + $urandom_range(123));
               vals[CSR_SHADE_LIMIT]        = REG_W'($urandom_range(600));
            end
            2: vals = '{default: '0};
            3: vals = '{default: REG_W'(LIGHT_MAX)};
            4: foreach (vals[k]) vals[k] = REG_W'($urandom_range(LIGHT_MAX));
            default: ;
         endcase
         if (ph != 0) begin
            program_bands(vals);
         end else begin
            // first window spans the extremes with alternating motion, median lands
            // in the gap between the first and second bands; then a window at full scale
            for (int k = 0; k < WINDOW_LEN; k++) begin
               it.light  = first_win[k];
               it.motion = k[0];
               sample_q.push_back(it);
            end
            for (int k = 0; k < WINDOW_LEN; k++) begin
               it.light  = LIGHT_W'(LIGHT_MAX);
               it.motion = (k != 2 && k != 3);
               sample_q.push_back(it);
            end
         end
         queue_windows(PHASE_WINS);
         if (ph == 4) pressure_go = 1'b1;
         settle();
      end
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
